// ----- design/instantaneous_frequency_estimator_macros.svh -----
// assertion macros for the instantaneous frequency estimator
`ifndef INSTANTANEOUS_FREQUENCY_ESTIMATOR_MACROS_SVH
`define INSTANTANEOUS_FREQUENCY_ESTIMATOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define IFE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define IFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ife_pkg.sv -----
// types and constants of the instantaneous frequency estimator
package ife_pkg;

    // binary angle, a full turn is 2^32
    typedef logic [31:0] t_angle;

    // datapath width: samples scaled to 40 bits plus cordic growth and sign
    localparam int XW = 42;
    localparam int SCALED_WIDTH = 40;

    localparam t_angle QUARTER_TURN       = 32'h4000_0000;
    localparam t_angle THREE_QUARTER_TURN = 32'hC000_0000;

    // atan(2^-i) as a fraction of a full turn, scaled by 2^32, rounded
    localparam t_angle ATAN_TURNS [0:31] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

endpackage

// ----- design/instantaneous_frequency_estimator.sv -----
// instantaneous frequency estimator: pipelined cordic atan2 and phase step
// a result item is registered in stage 0, in each rotation stage and in the result register before it shows on o_valid
// throughput: one item per cycle while the result side does not stall, set by one cordic rotation per pipeline stage
// stages compact around bubbles, so an item enters while a result waits to be taken
// reset (synchronous, active low) empties the pipeline and clears the stored phase
`include "instantaneous_frequency_estimator_macros.svh"

module instantaneous_frequency_estimator
    import ife_pkg::*;
#(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int PHASE_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input item channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_phase,
    input  logic signed [SAMPLE_WIDTH-1:0] i_quadrature,
    input  logic                          i_block_start,
    // result item channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [PHASE_WIDTH:0]   o_freq_step
);

    localparam int GUARD_SHIFT = SCALED_WIDTH - SAMPLE_WIDTH;
    localparam int RND_SHIFT   = 32 - PHASE_WIDTH;
    // half an lsb of the final phase, zero when the phase keeps all 32 bits
    localparam t_angle ROUND_HALF = t_angle'((33'd1 << RND_SHIFT) >> 1);
    localparam logic [PHASE_WIDTH-1:0] HALF_TURN = {1'b1, {(PHASE_WIDTH-1){1'b0}}};

    // pipeline stage registers: stage 0 after pre-rotation, stage k after k rotations
    logic signed [XW-1:0]   r_x     [0:CORDIC_STAGES];
    logic signed [XW-1:0]   r_y     [0:CORDIC_STAGES];
    t_angle                 r_z     [0:CORDIC_STAGES];
    logic                   r_start [0:CORDIC_STAGES];
    logic                   r_zero  [0:CORDIC_STAGES];
    logic [CORDIC_STAGES:0] r_vld;

    // per-stage advance: a stage loads when it is empty or its item moves on
    logic [CORDIC_STAGES+1:0] w_adv;

    // phase-difference state and result register
    logic [PHASE_WIDTH-1:0]  r_prev;
    logic                    r_have;
    logic                    r_out_valid;
    logic signed [PHASE_WIDTH:0] r_freq;

    // result register is free when empty or being taken
    assign w_adv[CORDIC_STAGES+1] = !r_out_valid || !i_stall;

    genvar k;
    generate
        for (k = 0; k <= CORDIC_STAGES; k++) begin : g_adv
            assign w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    endgenerate

    assign o_stall = !w_adv[0];

    // scale the samples up to the full datapath precision
    logic signed [XW-1:0] w_x_in;
    logic signed [XW-1:0] w_y_in;
    logic signed [XW-1:0] n_x0;
    logic signed [XW-1:0] n_y0;
    t_angle               n_z0;

    assign w_x_in = XW'(i_in_phase) <<< GUARD_SHIFT;
    assign w_y_in = XW'(i_quadrature) <<< GUARD_SHIFT;

    // fold the left half-plane onto the right by a quarter-turn rotation
    always_comb begin
        n_x0 = w_x_in;
        n_y0 = w_y_in;
        n_z0 = '0;
        if (w_x_in[XW-1]) begin
            if (!w_y_in[XW-1]) begin
                n_x0 = w_y_in;
                n_y0 = -w_x_in;
                n_z0 = QUARTER_TURN;
            end else begin
                n_x0 = -w_y_in;
                n_y0 = w_x_in;
                n_z0 = THREE_QUARTER_TURN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_adv[0]) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_x[0]     <= n_x0;
            r_y[0]     <= n_y0;
            r_z[0]     <= n_z0;
            r_start[0] <= i_block_start;
            // atan2 of the origin is defined as zero
            r_zero[0]  <= (i_in_phase == '0) && (i_quadrature == '0);
        end
    end

    // vectoring rotations, one per stage, driving y towards zero
    genvar i;
    generate
        for (i = 0; i < CORDIC_STAGES; i++) begin : g_stage
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[i+1] <= 1'b0;
                end else if (w_adv[i+1]) begin
                    r_vld[i+1] <= r_vld[i];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_adv[i+1]) begin
                    if (!r_y[i][XW-1]) begin
                        r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                        r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                        r_z[i+1] <= r_z[i] + ATAN_TURNS[i];
                    end else begin
                        r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                        r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                        r_z[i+1] <= r_z[i] - ATAN_TURNS[i];
                    end
                    r_start[i+1] <= r_start[i];
                    r_zero[i+1]  <= r_zero[i];
                end
            end
        end
    endgenerate

    // round the angle to the output phase width, half rounds up
    t_angle                 w_round;
    logic [PHASE_WIDTH-1:0] w_phase;
    logic [PHASE_WIDTH-1:0] w_step;
    logic                   w_consume;
    logic                   w_emit;

    assign w_round = r_z[CORDIC_STAGES] + ROUND_HALF;
    assign w_phase = r_zero[CORDIC_STAGES] ? '0 : w_round[31:RND_SHIFT];

    // step modulo a full turn; above half a turn it wraps negative,
    // an exact half turn stays positive
    assign w_step    = w_phase - r_prev;
    assign w_consume = r_vld[CORDIC_STAGES] && w_adv[CORDIC_STAGES+1];
    // the first sample of a block, or after reset, only loads the stored phase
    assign w_emit    = !r_start[CORDIC_STAGES] && r_have;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_have      <= 1'b0;
            r_prev      <= '0;
        end else begin
            if (w_adv[CORDIC_STAGES+1]) begin
                r_out_valid <= w_consume && w_emit;
            end
            if (w_consume) begin
                r_have <= 1'b1;
                r_prev <= w_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[CORDIC_STAGES+1]) begin
            r_freq <= {(w_step > HALF_TURN), w_step};
        end
    end

    assign o_valid     = r_out_valid;
    assign o_freq_step = r_freq;

    // a result only ever follows a stored phase
    `IFE_ASSERT_NOW(a_result_needs_prev, o_valid, r_have, "result item without a stored phase")

    // a negative step must come from a wrap above half a turn
    `IFE_ASSERT_NOW(a_wrap_range, o_valid && o_freq_step[PHASE_WIDTH], o_freq_step[PHASE_WIDTH-1:0] > HALF_TURN, "freq_step outside the wrapped range")

    // an accepted item always lands in the first stage
    `IFE_ASSERT_NEXT(a_accept_loads, i_valid && !o_stall, r_vld[0], "accepted item lost at the pipeline entry")

endmodule

// ----- tb/ife_step_checker.sv -----
// checker for the frequency estimator: predicts each phase step and compares the result items
module ife_step_checker
    import ife_pkg::*;
#(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int PHASE_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_phase,
    input  logic signed [SAMPLE_WIDTH-1:0] i_quadrature,
    input  logic                           i_block_start,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic signed [PHASE_WIDTH:0]    i_freq_step,
    output int                             o_fail_count,
    output int                             o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // atan(2^-i) in 2^32 parts of a turn
    bit [31:0] arctan_turn [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    logic signed [PHASE_WIDTH:0] pending_steps [$];
    logic [PHASE_WIDTH-1:0]      last_angle;
    bit                          have_last;
    int                          fails;

    // vectoring cordic, angle rounded to the phase width
    function automatic logic [PHASE_WIDTH-1:0] sample_angle(longint re, longint im);
        longint    x;
        longint    y;
        longint    t;
        longint    dx;
        longint    dy;
        bit [31:0] z;
        bit [63:0] zz;
        if (re == 0 && im == 0) begin
            return '0;
        end
        x = re <<< (40 - SAMPLE_WIDTH);
        y = im <<< (40 - SAMPLE_WIDTH);
        z = '0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = QUARTER_TURN;
            end else begin
                x = -y;
                y = t;
                z = THREE_QUARTER_TURN;
            end
        end
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_turn[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_turn[i];
            end
        end
        zz = {32'd0, z} + ((64'd1 << (32 - PHASE_WIDTH)) >> 1);
        return PHASE_WIDTH'(zz >> (32 - PHASE_WIDTH));
    endfunction

    always @(posedge i_clk) begin
        logic [PHASE_WIDTH-1:0]      angle;
        logic [PHASE_WIDTH-1:0]      delta;
        logic signed [PHASE_WIDTH:0] want;
        if (!i_rst_n) begin
            pending_steps.delete();
            last_angle = '0;
            have_last  = 1'b0;
            fails      = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_steps.size() == 0) begin
                    $error("freq_step: unexpected item, got %0d", i_freq_step);
                    fails++;
                end else begin
                    want = pending_steps.pop_front();
                    if (i_freq_step !== want) begin
                        $error("freq_step: expected %0d, got %0d", want, i_freq_step);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                angle = sample_angle(i_in_phase, i_quadrature);
                if (i_block_start || !have_last) begin
                    have_last = 1'b1;
                end else begin
                    delta = angle - last_angle;
                    // a step above half a turn wraps negative, half a turn stays positive
                    want  = {(delta > (1 << (PHASE_WIDTH - 1))), delta};
                    pending_steps.push_back(want);
                end
                last_angle = angle;
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= pending_steps.size();
    end

endmodule

// ----- tb/tb.sv -----
// top of the frequency estimator testbench: stimulus, result stalls and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW             = 16;
    localparam int PW             = 16;
    localparam int STAGES         = 16;
    localparam int LATENCY        = STAGES + 1;
    localparam int RANDOM_ITEMS   = 1930;
    localparam int SQUEEZE_AFTER  = 400;    // items sent before the long hold-off
    localparam int SQUEEZE_CYCLES = 300;
    localparam int CYCLE_LIMIT    = 1000000;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_valid       = 1'b0;
    logic signed [SW-1:0] i_in_phase    = '0;
    logic signed [SW-1:0] i_quadrature  = '0;
    logic                 i_block_start = 1'b0;
    logic                 i_stall       = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic signed [PW:0]   o_freq_step;

    int          fail_count;
    int          outstanding;
    int          items_sent = 0;
    int unsigned cycles_run = 0;

    instantaneous_frequency_estimator #(
        .SAMPLE_WIDTH  (SW),
        .PHASE_WIDTH   (PW),
        .CORDIC_STAGES (STAGES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_in_phase    (i_in_phase),
        .i_quadrature  (i_quadrature),
        .i_block_start (i_block_start),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_freq_step   (o_freq_step)
    );

    // the checker watches both channels on its own
    ife_step_checker #(
        .SAMPLE_WIDTH  (SW),
        .PHASE_WIDTH   (PW),
        .CORDIC_STAGES (STAGES)
    ) u_step_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_in_phase    (i_in_phase),
        .i_quadrature  (i_quadrature),
        .i_block_start (i_block_start),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_freq_step   (o_freq_step),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog, far above the slowest legal run
    always @(posedge i_clk) begin
        cycles_run <= cycles_run + 1;
        if (cycles_run >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // idle length between items: mostly none, some short, a few long
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // one of the corner values of a sample component
    function automatic logic signed [SW-1:0] corner_value();
        case ($urandom_range(0, 4))
            0: return SW'(-32768);
            1: return SW'(-1);
            2: return SW'(0);
            3: return SW'(1);
            default: return SW'(32767);
        endcase
    endfunction

    // offer one sample and hold it until the block takes it
    task automatic push_sample(input logic signed [SW-1:0] re, input logic signed [SW-1:0] im,
                               input logic bs);
        int gap;
        // every fifth stretch of 150 items goes back to back
        gap = ((items_sent / 150) % 5 == 2) ? 0 : idle_cycles();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_in_phase    <= re;
        i_quadrature  <= im;
        i_block_start <= bs;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    // random sample of one of several flavours
    task automatic random_sample(output logic signed [SW-1:0] re,
                                 output logic signed [SW-1:0] im);
        int                   r;
        logic signed [SW-1:0] a;
        r = $urandom_range(0, 99);
        a = SW'($urandom);
        if (r < 40) begin
            // full range, every bit toggles
            re = SW'($urandom);
            im = SW'($urandom);
        end else if (r < 60) begin
            // tiny vectors near the origin, zero among them
            re = SW'($urandom_range(0, 8)) - SW'(4);
            im = SW'($urandom_range(0, 8)) - SW'(4);
        end else if (r < 75) begin
            re = corner_value();
            im = corner_value();
        end else begin
            // on an axis or a diagonal, where half turns and quadrant edges sit
            case ($urandom_range(0, 5))
                0: begin re = a;  im = '0; end
                1: begin re = '0; im = a;  end
                2: begin re = a;  im = a;  end
                3: begin re = a;  im = -a; end
                4: begin re = -a; im = '0; end
                default: begin re = '0; im = -a; end
            endcase
        end
    endtask

    // result side: random stalls, one long hold-off once the pipe is busy
    initial begin : result_sink
        int hold;
        int r;
        bit squeezed;
        hold     = 0;
        squeezed = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                i_stall <= 1'b1;
            end else if (!squeezed && items_sent >= SQUEEZE_AFTER) begin
                // sender keeps offering, so the block fills and stalls its input
                squeezed = 1'b1;
                hold     = SQUEEZE_CYCLES - 1;
                i_stall <= 1'b1;
            end else if ((cycles_run / 700) % 5 == 3) begin
                i_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    i_stall <= 1'b0;
                end else begin
                    hold = (r < 97) ? $urandom_range(0, 2) : $urandom_range(15, 60);
                    i_stall <= 1'b1;
                end
            end
        end
    end

    // stimulus and verdict
    initial begin : sample_source
        logic signed [SW-1:0] re;
        logic signed [SW-1:0] im;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first sample after reset without the flag still only loads the phase
        push_sample(0, 0, 1'b0);
        push_sample(0, 0, 1'b0);            // zero sample, zero step
        push_sample(1, 0, 1'b0);
        push_sample(-1, 0, 1'b0);           // exact half turn forwards
        push_sample(1, 0, 1'b0);            // and back, still positive
        push_sample(0, 1, 1'b0);
        push_sample(0, -1, 1'b0);
        push_sample(-1, -1, 1'b0);          // negative x, negative y
        push_sample(-1, 1, 1'b0);           // negative x, positive y
        push_sample(32767, 32767, 1'b0);
        push_sample(-32768, -32768, 1'b0);
        push_sample(-32768, 32767, 1'b0);
        push_sample(32767, -32768, 1'b0);
        push_sample(-32768, 0, 1'b0);
        push_sample(0, -32768, 1'b0);
        push_sample(32767, 0, 1'b0);
        push_sample(0, 0, 1'b0);
        push_sample(5, 5, 1'b1);            // block start in mid stream
        push_sample(-5, -5, 1'b0);
        push_sample(-32768, -32768, 1'b1);
        push_sample(-32768, -32768, 1'b1);  // two block starts in a row
        push_sample(3, -7, 1'b0);
        push_sample(0, 0, 1'b0);

        repeat (RANDOM_ITEMS) begin
            random_sample(re, im);
            push_sample(re, im, ($urandom_range(0, 9) == 0));
        end
        i_valid <= 1'b0;

        // let the outstanding count take in the last item
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        // room for any stray item still in the pipe
        repeat (4 * LATENCY) @(posedge i_clk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
